[hw/rtl/sps_pkg.sv]
// package for the stepper phase sequencer: widths, request codes and phase tables
`default_nettype none

package sps_pkg;

    localparam int STEP_COUNT_BITS = 16;
    localparam int MOVE_BITS       = 16;
    localparam int MAG_BITS        = MOVE_BITS + 1;
    localparam int CMP_BITS        = (STEP_COUNT_BITS > MAG_BITS) ? STEP_COUNT_BITS : MAG_BITS;

    localparam int IN_TDATA_BITS   = 24;
    localparam int OUT_TDATA_BITS  = 8;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_MOVE = 2'd1,
        FUNC_HOLD = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    localparam logic [2:0] FULL_START = 3'd2;
    localparam logic [2:0] HALF_START = 3'd0;
    localparam logic [2:0] HALF_REHOLD = 3'd1;

    // line bits: [0] a, [1] b, [2] a_bar, [3] b_bar
    function automatic logic [3:0] full_lines(input logic [1:0] phase);
        logic [3:0] lines;
        unique case (phase)
            2'd0: lines = 4'b0011;
            2'd1: lines = 4'b0010;
            2'd2: lines = 4'b0000;
            2'd3: lines = 4'b0001;
            default: lines = 4'b0000;
        endcase
        return lines;
    endfunction

    function automatic logic [3:0] half_lines(input logic [2:0] phase);
        logic [3:0] lines;
        unique case (phase)
            3'd0: lines = 4'b0001;
            3'd1: lines = 4'b0011;
            3'd2: lines = 4'b0010;
            3'd3: lines = 4'b0110;
            3'd4: lines = 4'b0100;
            3'd5: lines = 4'b1100;
            3'd6: lines = 4'b1000;
            3'd7: lines = 4'b1001;
            default: lines = 4'b0000;
        endcase
        return lines;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/stepper_phase_sequencer_unit.sv]
// stepper motor full/half step phase sequencer, top level
`default_nettype none

// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: move_steps, hold_value; tuser: func
// m_axis    out  m_axis_tvalid/tready       tdata: a, b, a_bar, b_bar, moving, hold_error
// cfg       in   i_cfg_wr_en (no wait)      i_cfg_wr_data: half_step_mode
//
// one request per cycle, one result per request, result in the cycle after acceptance
// state updates on accept unless a mode write wins; the result goes to the output register
// a held result does not block intake while downstream takes it in the same cycle
// when the output register is full and m_axis_tready is low, s_axis_tready drops
// synchronous active-low reset: full-step mode, phase 2, no steps left, forward

module stepper_phase_sequencer_unit
    import sps_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic                      i_cfg_wr_data,   // half_step_mode
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,    // [15:0] move_steps, [16] hold_value
    input  wire logic [1:0]                s_axis_tuser,    // [1:0] func
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata     // [0] a [1] b [2] a_bar [3] b_bar
                                                            // [4] moving [5] hold_error
);

    // sequencer state
    logic                       r_half_mode;
    logic [2:0]                 r_phase;
    logic                       r_released;
    logic                       r_reverse;
    logic [STEP_COUNT_BITS-1:0] r_steps;

    logic                       n_phase_dummy_unused;
    logic [2:0]                 n_phase;
    logic                       n_released;
    logic                       n_reverse;
    logic [STEP_COUNT_BITS-1:0] n_steps;
    logic                       n_err;
    logic [3:0]                 n_lines;

    // output register
    logic                       r_out_valid;
    logic [5:0]                 r_out_data;

    logic                       s_accept;
    t_func                      in_func;
    logic [MOVE_BITS-1:0]       in_raw;
    logic                       in_hold;
    logic [MAG_BITS-1:0]        mag;
    logic [CMP_BITS-1:0]        mag_ext;
    logic [CMP_BITS-1:0]        max_ext;

    assign in_func  = t_func'(s_axis_tuser);
    assign in_raw   = s_axis_tdata[MOVE_BITS-1:0];
    assign in_hold  = s_axis_tdata[MOVE_BITS];

    // intake is open when the output slot is empty or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // move magnitude, saturated to the step counter width
    always_comb begin
        if (in_raw[MOVE_BITS-1]) begin
            mag = (MAG_BITS'(1) << MOVE_BITS) - MAG_BITS'(in_raw);
        end else begin
            mag = MAG_BITS'(in_raw);
        end
        mag_ext = CMP_BITS'(mag);
        max_ext = CMP_BITS'({STEP_COUNT_BITS{1'b1}});
    end

    // next state and result for the request at the input
    always_comb begin
        n_phase    = r_phase;
        n_released = r_released;
        n_reverse  = r_reverse;
        n_steps    = r_steps;
        n_err      = 1'b0;
        n_phase_dummy_unused = 1'b0;

        unique case (in_func)
            FUNC_TICK: begin
                if (r_steps != '0) begin
                    n_steps = r_steps - STEP_COUNT_BITS'(1);
                    if (r_half_mode) begin
                        // a tick from the free state re-engages at the half start position
                        if (r_released) begin
                            n_released = 1'b0;
                            n_phase    = HALF_START;
                        end else if (r_reverse) begin
                            n_phase = r_phase - 3'd1;
                        end else begin
                            n_phase = r_phase + 3'd1;
                        end
                    end else begin
                        if (r_reverse) begin
                            n_phase = {1'b0, r_phase[1:0] - 2'd1};
                        end else begin
                            n_phase = {1'b0, r_phase[1:0] + 2'd1};
                        end
                    end
                end
            end
            FUNC_MOVE: begin
                // new count replaces whatever was left
                n_reverse = in_raw[MOVE_BITS-1];
                n_steps   = (mag_ext > max_ext) ? STEP_COUNT_BITS'(max_ext)
                                                : STEP_COUNT_BITS'(mag_ext);
            end
            FUNC_HOLD: begin
                if (!r_half_mode) begin
                    n_err = 1'b1;
                end else if (!in_hold && !r_released) begin
                    n_released = 1'b1;
                end else if (in_hold && r_released) begin
                    n_released = 1'b0;
                    n_phase    = HALF_REHOLD;
                end
            end
            FUNC_NONE: begin
                n_phase_dummy_unused = 1'b1;
            end
            default: begin
                n_phase_dummy_unused = 1'b1;
            end
        endcase

        // line levels after the request; free state drives everything low
        if (r_half_mode) begin
            n_lines = n_released ? 4'b0000 : half_lines(n_phase);
        end else begin
            n_lines = full_lines(n_phase[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_mode <= 1'b0;
            r_phase     <= FULL_START;
            r_released  <= 1'b0;
            r_reverse   <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                // mode write restarts the position, keeps steps and direction
                r_half_mode <= i_cfg_wr_data;
                r_phase     <= i_cfg_wr_data ? HALF_START : FULL_START;
                r_released  <= i_cfg_wr_data;
            end else if (s_accept) begin
                r_phase    <= n_phase;
                r_released <= n_released;
                r_reverse  <= n_reverse;
                r_steps    <= n_steps;
            end

            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= {n_err, (n_steps != '0) && !n_phase_dummy_unused
                                  || (n_phase_dummy_unused && (r_steps != '0)),
                           n_lines};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data};

endmodule

`default_nettype wire
